// ===== src/shazp_pkg.sv =====
// ----------------------------------------------------------------------------
// shazp_pkg
// Constants and helpers for the chained SHA-256 zero-prefix search.
// ----------------------------------------------------------------------------
package shazp_pkg;

  localparam int unsigned NibbleCap = 32;

  localparam logic [1:0] ACT_APPEND        = 2'd0;
  localparam logic [1:0] ACT_APPEND_SEARCH = 2'd1;
  localparam logic [1:0] ACT_SEARCH        = 2'd2;
  localparam logic [1:0] ACT_NONE          = 2'd3;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha256_chain_zero_prefix_search.sv =====
// ----------------------------------------------------------------------------
// sha256_chain_zero_prefix_search
// Loads a short message, hashes it, then rehashes the digest until it shows
// the required number of leading zero nibbles.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  command   in         start_i, busy_o, action_i, data_byte_i
//  result    out        result_valid_o, digest_word0..3_o, hash_count_o,
//                       message_overflow_o
//  config    in         cfg_we_i, cfg_wdata_i
//
//  An append is taken while idle. Each hash of a search runs fill, which loads
//  the block a byte a cycle (its first step only addresses the store), then 64
//  rounds of the shared round unit, a fold of the chain value and a test of the
//  prefix. The strobe state follows, and busy stays high through it too.
//  The hash count saturates at all ones. The receiver cannot stall.
//  Reset clears length, overflow flag, count and the sequencer.
// ----------------------------------------------------------------------------
module sha256_chain_zero_prefix_search
  import shazp_pkg::*;
#(
  parameter int unsigned MSG_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic [63:0] digest_word0_o,
  output logic [63:0] digest_word1_o,
  output logic [63:0] digest_word2_o,
  output logic [63:0] digest_word3_o,
  output logic [63:0] hash_count_o,
  output logic        message_overflow_o
);

  localparam int unsigned LenW = $clog2(MSG_BYTES + 1);
  localparam int unsigned IdxW = $clog2(MSG_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [5:0]      need_q;
  logic [LenW-1:0] len_q;
  logic            ovf_q;
  logic [63:0]     cnt_q;
  logic [7:0]      mem [MSG_BYTES];
  logic [7:0]      rd_q;
  logic [6:0]      fill_q;   // block byte index during fill
  logic            rd_ok_q;  // rd_q holds byte fill_q-1 from memory
  logic            chain_q;  // hashing previous digest
  logic [511:0]    blk_q;    // block, shifted left one word per round
  logic [31:0]     w_q [16];
  logic [31:0]     v_q [8];
  logic [255:0]    dig_q;
  logic [5:0]      rnd_q;

  assign busy_o = (state_q != S_IDLE);

  // message store
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o && (action_i == ACT_APPEND || action_i == ACT_APPEND_SEARCH)
        && len_q < LenW'(MSG_BYTES))
      mem[len_q[IdxW-1:0]] <= data_byte_i;
    rd_q <= mem[fill_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 6'd2;
    end else if (cfg_we_i) begin
      need_q <= cfg_wdata_i;
    end
  end

  // one round of the shared compression unit
  logic [31:0] w_cur, w_new, t1, t2, s0, s1, ch, mj, ws0, ws1;
  logic [31:0] v_fold [8];
  logic [255:0] dig_new;
  logic        zero_ok;
  logic [5:0]  need_c;

  always_comb begin
    ws0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    ws1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + ws0 + w_q[9] + ws1;
    w_cur = (rnd_q < 6'd16) ? blk_q[511:480] : w_new;
    s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + ROUND_K[rnd_q] + w_cur;
    s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
    for (int i = 0; i < 8; i++) v_fold[i] = INIT_H[i] + v_q[i];
    dig_new = {v_fold[0], v_fold[1], v_fold[2], v_fold[3],
               v_fold[4], v_fold[5], v_fold[6], v_fold[7]};
    need_c = (need_q > 6'(NibbleCap)) ? 6'(NibbleCap) : need_q;
    zero_ok = 1'b1;
    for (int k = 0; k < 32; k++)
      if (6'(k) < need_c && dig_q[255-4*k -: 4] != 4'd0) zero_ok = 1'b0;
  end

  logic [LenW-1:0] blen;
  logic [15:0]     bits;
  assign blen = chain_q ? LenW'(32) : len_q;
  assign bits = {7'd0, blen, 3'd0} >> 0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i && (action_i == ACT_APPEND_SEARCH || action_i == ACT_SEARCH))
                state_d = S_FILL;
      S_FILL:  if (fill_q == 7'd64) state_d = S_ROUND;
      S_ROUND: if (rnd_q == 6'd63) state_d = S_FOLD;
      S_FOLD:  state_d = S_TEST;
      S_TEST:  state_d = (need_q == 6'd0 || zero_ok) ? S_DONE : S_FILL;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      fill_q  <= '0;
      rnd_q   <= '0;
      chain_q <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (start_i && (action_i == ACT_APPEND || action_i == ACT_APPEND_SEARCH)) begin
            if (len_q < LenW'(MSG_BYTES)) len_q <= len_q + 1'b1;
            else ovf_q <= 1'b1;
          end
          cnt_q   <= '0;
          chain_q <= 1'b0;
          fill_q  <= '0;
          rd_ok_q <= 1'b0;
        end
        S_FILL: begin
          // byte at fill_q-1 is now in rd_q (chained: from dig_q)
          if (rd_ok_q) begin
            logic [7:0] b;
            logic [6:0] p;
            p = fill_q - 7'd1;
            if (chain_q && p < 7'd32) b = dig_q[255 - 8*p[4:0] -: 8];
            else if (!chain_q && {1'b0, p} < 8'(blen)) b = rd_q;
            else if ({1'b0, p} == 8'(blen)) b = 8'h80;
            else if (p == 7'd62) b = bits[15:8];
            else if (p == 7'd63) b = bits[7:0];
            else b = 8'h00;
            blk_q <= {blk_q[503:0], b};
          end
          rd_ok_q <= 1'b1;
          if (fill_q != 7'd64) fill_q <= fill_q + 7'd1;
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= INIT_H[i];
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= w_cur;
          blk_q <= {blk_q[479:0], 32'd0};
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 6'd1;
        end
        S_FOLD: begin
          dig_q <= dig_new;
          if (cnt_q != '1) cnt_q <= cnt_q + 64'd1;
        end
        S_TEST: begin
          chain_q <= 1'b1;
          fill_q  <= '0;
          rd_ok_q <= 1'b0;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  assign result_valid_o     = (state_q == S_DONE);
  assign digest_word0_o     = dig_q[255:192];
  assign digest_word1_o     = dig_q[191:128];
  assign digest_word2_o     = dig_q[127:64];
  assign digest_word3_o     = dig_q[63:0];
  assign hash_count_o       = cnt_q;
  assign message_overflow_o = ovf_q;

endmodule

// ===== test/tb_sha256_chain_zero_prefix_search.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_chain_zero_prefix_search
// Self-checking bench: loads bytes, runs searches under several zero-nibble
// settings and idling phases, and checks each digest and hash count against
// a behavioural SHA-256 chain computed in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha256_chain_zero_prefix_search;
  import shazp_pkg::*;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [255:0] digest;
    logic [63:0]  count;
    logic         overflow;
  } search_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  action_i = ACT_NONE;
  logic [7:0]  data_byte_i = 8'h00;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = 6'd0;
  logic        busy_o;
  logic        result_valid_o;
  logic [63:0] digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o;
  logic [63:0] hash_count_o;
  logic        message_overflow_o;

  cmd_t        pending_cmds[$];
  search_res_t expected_results[$];
  int unsigned idle_pct = 0;
  int unsigned n_errors = 0;

  // bench copy of the message store, overflow flag and nibble setting
  logic [7:0]  msg_bytes[32];
  int unsigned msg_len = 0;
  logic        dropped = 1'b0;
  logic [5:0]  zero_nibbles = 6'd2;

  sha256_chain_zero_prefix_search u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .data_byte_i,
    .cfg_we_i, .cfg_wdata_i, .result_valid_o,
    .digest_word0_o, .digest_word1_o, .digest_word2_o, .digest_word3_o,
    .hash_count_o, .message_overflow_o
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  // single padded block SHA-256 of len bytes (len <= 32)
  function automatic logic [255:0] sha_block(input logic [7:0] m[32], input int unsigned len);
    logic [7:0]  blk[64];
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    logic [255:0] d;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 32; i++) if (i < len) blk[i] = m[i];
    blk[len] = 8'h80;
    blk[62] = 8'((len * 8) >> 8);
    blk[63] = 8'(len * 8);
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end else begin
        w[i] = w[i-16] + w[i-7]
             + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
             + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      end
    end
    for (int i = 0; i < 8; i++) v[i] = INIT_H[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) d[255 - 32*i -: 32] = INIT_H[i] + v[i];
    return d;
  endfunction

  function automatic search_res_t chain_search();
    search_res_t r;
    logic [7:0]  buf_b[32];
    int unsigned need;
    need = (zero_nibbles > NibbleCap) ? NibbleCap : zero_nibbles;
    r.count = 64'd0;
    r.digest = sha_block(msg_bytes, msg_len);
    forever begin
      if (r.count != '1) r.count++;
      if (need == 0 || (r.digest >> (256 - need * 4)) == 0) break;
      for (int i = 0; i < 32; i++) buf_b[i] = r.digest[255 - 8*i -: 8];
      r.digest = sha_block(buf_b, 32);
    end
    r.overflow = dropped;
    return r;
  endfunction

  // driver: holds an item until the transfer, then maybe idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (action_i == ACT_APPEND || action_i == ACT_APPEND_SEARCH) begin
          if (msg_len < 32) begin
            msg_bytes[msg_len] = data_byte_i;
            msg_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (action_i == ACT_APPEND_SEARCH || action_i == ACT_SEARCH)
          expected_results.push_back(chain_search());
      end
      if (!start_i || !busy_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          start_i <= 1'b1;
          action_i <= c.action;
          data_byte_i <= c.data_byte;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual digest %h %h %h %h", $time,
                 digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o);
        n_errors++;
      end else begin
        search_res_t e;
        e = expected_results.pop_front();
        if ({digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o} !== e.digest) begin
          $display("%0t: digest mismatch, expected %h actual %h %h %h %h", $time, e.digest,
                   digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o);
          n_errors++;
        end
        if (hash_count_o !== e.count) begin
          $display("%0t: hash_count mismatch, expected %0d actual %0d", $time,
                   e.count, hash_count_o);
          n_errors++;
        end
        if (message_overflow_o !== e.overflow) begin
          $display("%0t: message_overflow mismatch, expected %b actual %b", $time,
                   e.overflow, message_overflow_o);
          n_errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_nibbles(input logic [5:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    zero_nibbles = val;
  endtask

  task automatic queue_cmd(input logic [1:0] act, input logic [7:0] b);
    cmd_t c;
    c.action = act;
    c.data_byte = b;
    pending_cmds.push_back(c);
  endtask

  initial begin
    cmd_t c;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message under the reset requirement
    queue_cmd(ACT_SEARCH, 8'h00);
    write_nibbles(6'd0);
    queue_cmd(ACT_SEARCH, 8'h00);
    queue_cmd(ACT_APPEND, 8'h00);
    queue_cmd(ACT_APPEND, 8'hff);
    queue_cmd(ACT_NONE, 8'h5a);
    queue_cmd(ACT_APPEND_SEARCH, 8'h80);
    queue_cmd(ACT_SEARCH, 8'h00);
    queue_cmd(ACT_SEARCH, 8'h00);   // repeated search, same message
    write_nibbles(6'd32);
    write_nibbles(6'd63);
    write_nibbles(6'd1);
    queue_cmd(ACT_APPEND_SEARCH, 8'h01);
    queue_cmd(ACT_SEARCH, 8'h00);
    write_nibbles(6'd2);
    queue_cmd(ACT_APPEND_SEARCH, 8'h7f);

    for (int p = 0; p < 4; p++) begin
      write_nibbles((p % 2) ? 6'd1 : 6'd0);
      idle_pct = (p == 0) ? 0 : (p == 3) ? 27 : 61;
      for (int i = 0; i < 330; i++) begin
        int unsigned r;
        r = $urandom_range(99);
        c.data_byte = 8'($urandom);
        c.action = (r < 82) ? ACT_APPEND : (r < 90) ? ACT_APPEND_SEARCH :
                   (r < 97) ? ACT_SEARCH : ACT_NONE;
        pending_cmds.push_back(c);
      end
    end
    wait_drained();
    if (n_errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
